### hdl/skf_pkg.sv
// package for the scalar kalman filter: default sizes, register indexes and
// the state types of the sequencer and the serial arithmetic units
// no dependencies
package skf_pkg;

  localparam int unsigned DEF_DATA_WIDTH = 32;
  localparam int unsigned DEF_FRAC_BITS  = 16;

  localparam int unsigned CFG_IDX_W = 2;

  localparam logic [CFG_IDX_W-1:0] CFG_TRANSITION  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_OBSERVATION = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_PROC_NOISE  = 2'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_MEAS_NOISE  = 2'd3;

  typedef enum logic [1:0] {
    MUL_IDLE,
    MUL_RUN,
    MUL_ROUND,
    MUL_SAT
  } mul_state_e;

  typedef enum logic [1:0] {
    DIV_IDLE,
    DIV_RUN,
    DIV_FIX
  } div_state_e;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_XP,
    ST_FP,
    ST_PP,
    ST_PH,
    ST_DEN,
    ST_DIV,
    ST_HX,
    ST_ERR,
    ST_XU,
    ST_KH,
    ST_OM,
    ST_PU,
    ST_OUT
  } step_e;

endpackage

### hdl/skf_mul.sv
// bit-serial signed fixed-point multiplier with round half up, addend and
// saturation to the signed or the covariance range; depends on skf_pkg
module skf_mul import skf_pkg::*; #(
  parameter int unsigned DATA_WIDTH = DEF_DATA_WIDTH,
  parameter int unsigned FRAC_BITS  = DEF_FRAC_BITS
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         start_i,
  input  logic signed [DATA_WIDTH-1:0] op_a_i,
  input  logic signed [DATA_WIDTH-1:0] op_b_i,
  input  logic signed [DATA_WIDTH-1:0] addend_i,
  input  logic                         cov_sat_i,
  output logic                         done_o,
  output logic signed [DATA_WIDTH-1:0] result_o
);

  localparam int unsigned W    = DATA_WIDTH;
  localparam int unsigned CntW = $clog2(W);
  localparam int unsigned RndW = 2 * W - FRAC_BITS + 2;

  localparam logic signed [RndW-1:0] SMAX_S = {{(RndW-W+1){1'b0}}, {(W-1){1'b1}}};
  localparam logic signed [RndW-1:0] SMIN_S = {{(RndW-W+1){1'b1}}, {(W-1){1'b0}}};

  mul_state_e state_q, state_d;

  logic [CntW-1:0]        cnt_q;
  logic signed [W:0]      hi_q;
  logic [W-1:0]           lo_q;
  logic signed [W-1:0]    a_q;
  logic signed [W-1:0]    addend_q;
  logic                   cov_q;
  logic signed [RndW-1:0] rnd_q;

  logic              last_bit;
  logic signed [W:0] a_ext;
  logic signed [W:0] pp_sum;
  logic [2*W:0]      prod;
  logic signed [RndW-1:0] sum_s;

  assign last_bit = (cnt_q == CntW'(W - 1));
  assign a_ext    = {a_q[W-1], a_q};
  // the sign bit of the multiplier weighs negative
  assign pp_sum   = !lo_q[0] ? hi_q : (last_bit ? hi_q - a_ext : hi_q + a_ext);
  assign prod     = {hi_q, lo_q};

  // drop the rounding bit, then add the addend
  assign sum_s = {rnd_q[RndW-1], rnd_q[RndW-1:1]}
               + {{(RndW-W){addend_q[W-1]}}, addend_q};

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      MUL_IDLE:  if (start_i) state_d = MUL_RUN;
      MUL_RUN:   if (last_bit) state_d = MUL_ROUND;
      MUL_ROUND: state_d = MUL_SAT;
      MUL_SAT:   state_d = MUL_IDLE;
      default:   state_d = MUL_IDLE;
    endcase
  end

  always_comb begin
    done_o = (state_q == MUL_SAT);
    if (sum_s > SMAX_S) begin
      result_o = {1'b0, {(W-1){1'b1}}};
    end else if (cov_q && sum_s[RndW-1]) begin
      result_o = '0;
    end else if (sum_s < SMIN_S) begin
      result_o = {1'b1, {(W-1){1'b0}}};
    end else begin
      result_o = sum_s[W-1:0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= MUL_IDLE;
      cnt_q   <= '0;
    end else begin
      state_q <= state_d;
      if (state_q == MUL_IDLE) begin
        cnt_q <= '0;
      end else if (state_q == MUL_RUN) begin
        cnt_q <= cnt_q + 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (state_q == MUL_IDLE && start_i) begin
      a_q      <= op_a_i;
      lo_q     <= op_b_i;
      hi_q     <= '0;
      addend_q <= addend_i;
      cov_q    <= cov_sat_i;
    end else if (state_q == MUL_RUN) begin
      hi_q <= {pp_sum[W], pp_sum[W:1]};
      lo_q <= {pp_sum[0], lo_q[W-1:1]};
    end
    if (state_q == MUL_ROUND) begin
      rnd_q <= prod[2*W:FRAC_BITS-1] + RndW'(1);
    end
  end

endmodule

### hdl/skf_div.sv
// bit-serial restoring divider for the gain: round(num * 2^frac / den),
// ties away from zero, saturated to the signed range; depends on skf_pkg
module skf_div import skf_pkg::*; #(
  parameter int unsigned DATA_WIDTH = DEF_DATA_WIDTH,
  parameter int unsigned FRAC_BITS  = DEF_FRAC_BITS
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         start_i,
  input  logic signed [DATA_WIDTH-1:0] num_i,
  input  logic signed [DATA_WIDTH-1:0] den_i,
  output logic                         done_o,
  output logic signed [DATA_WIDTH-1:0] quot_o
);

  localparam int unsigned W    = DATA_WIDTH;
  localparam int unsigned NB   = W + FRAC_BITS;
  localparam int unsigned CntW = $clog2(NB);

  div_state_e state_q, state_d;

  logic [CntW-1:0] cnt_q;
  logic [W-1:0]    rem_q;
  logic [NB-1:0]   dq_q;
  logic [W-1:0]    den_q;
  logic            neg_q;

  logic [W-1:0] mag_abs;
  logic [W:0]   trial;
  logic [W:0]   diff;
  logic         ge;
  logic         last_bit;
  logic         over;
  logic [W-1:0] qm;

  assign mag_abs  = num_i[W-1] ? (~num_i + 1'b1) : num_i;
  assign trial    = {rem_q, dq_q[NB-1]};
  assign diff     = trial - {1'b0, den_q};
  assign ge       = (trial >= {1'b0, den_q});
  assign last_bit = (cnt_q == CntW'(NB - 1));

  // clamp the magnitude to 2^(w-1) before the sign goes back on
  assign over = (dq_q > {{(NB-W){1'b0}}, 1'b1, {(W-1){1'b0}}});
  assign qm   = over ? {1'b1, {(W-1){1'b0}}} : dq_q[W-1:0];

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      DIV_IDLE: if (start_i) state_d = DIV_RUN;
      DIV_RUN:  if (last_bit) state_d = DIV_FIX;
      DIV_FIX:  state_d = DIV_IDLE;
      default:  state_d = DIV_IDLE;
    endcase
  end

  always_comb begin
    done_o = (state_q == DIV_FIX);
    if (neg_q) begin
      quot_o = ~qm + 1'b1;
    end else if (qm[W-1]) begin
      quot_o = {1'b0, {(W-1){1'b1}}};
    end else begin
      quot_o = qm;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= DIV_IDLE;
      cnt_q   <= '0;
    end else begin
      state_q <= state_d;
      if (state_q == DIV_IDLE) begin
        cnt_q <= '0;
      end else if (state_q == DIV_RUN) begin
        cnt_q <= cnt_q + 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (state_q == DIV_IDLE && start_i) begin
      // half the divisor is added up front for rounding
      dq_q  <= {mag_abs, {FRAC_BITS{1'b0}}} + {{(FRAC_BITS+1){1'b0}}, den_i[W-1:1]};
      rem_q <= '0;
      den_q <= den_i;
      neg_q <= num_i[W-1];
    end else if (state_q == DIV_RUN) begin
      rem_q <= ge ? diff[W-1:0] : trial[W-1:0];
      dq_q  <= {dq_q[NB-2:0], ge};
    end
  end

endmodule

### hdl/scalar_kalman_filter_top.sv
// scalar kalman filter, top level: step sequencer, state and config registers,
// stream ports; depends on skf_pkg, skf_mul and skf_div
//
//   channel   direction  handshake                contents
//   s_axis    in         tvalid/tready            tdata: measurement
//   m_axis    out        tvalid/tready            tdata: estimate, covariance, gain
//                                                 tuser: degenerate flag
//   cfg       in         cfg_we_i (no wait)       index 0 F, 1 H, 2 Q, 3 R
//
// the work per item is nine passes through the one-bit-per-cycle multiplier and,
// when the denominator is positive, DATA_WIDTH+FRAC_BITS quotient bits of the
// serial divider.
// reset loads x = 0, P = 1.0, F = H = 1.0 and Q = R = 0.1.
// a finished result waits in the output register while the next measurement
// is taken; the sequencer stalls before loading a new result until it drains.
module scalar_kalman_filter_top import skf_pkg::*; #(
  parameter int unsigned DATA_WIDTH = DEF_DATA_WIDTH,
  parameter int unsigned FRAC_BITS  = DEF_FRAC_BITS
) (
  input  logic                                   clk_i,
  input  logic                                   rst_ni,
  input  logic                                   s_axis_tvalid,
  output logic                                   s_axis_tready,
  // measurement
  input  logic [((DATA_WIDTH+7)/8)*8-1:0]        s_axis_tdata,
  output logic                                   m_axis_tvalid,
  input  logic                                   m_axis_tready,
  // filtered_estimate, error_covariance, kalman_gain
  output logic [((3*DATA_WIDTH-1+7)/8)*8-1:0]    m_axis_tdata,
  // degenerate_flag
  output logic                                   m_axis_tuser,
  input  logic                                   cfg_we_i,
  input  logic [CFG_IDX_W-1:0]                   cfg_index_i,
  input  logic [DATA_WIDTH-1:0]                  cfg_wdata_i
);

  localparam int unsigned W        = DATA_WIDTH;
  localparam int unsigned OutDataW = ((3 * W - 1 + 7) / 8) * 8;

  localparam longint unsigned ONE_L   = 64'd1 << FRAC_BITS;
  localparam longint unsigned TENTH_L = (ONE_L + 64'd5) / 64'd10;

  localparam logic signed [W-1:0] ONE_Q   = W'(ONE_L);
  localparam logic [W-2:0]        TENTH_Q = (W-1)'(TENTH_L);
  localparam logic signed [W-1:0] SMAX_W  = {1'b0, {(W-1){1'b1}}};
  localparam logic signed [W-1:0] SMIN_W  = {1'b1, {(W-1){1'b0}}};

  step_e state_q, state_d;

  logic signed [W-1:0] f_q, h_q;
  logic [W-2:0]        q_q, r_q;
  logic signed [W-1:0] x_q, p_q;
  logic signed [W-1:0] z_q, xp_q, pp_q, ph_q, den_q, k_q, e_q, om_q, t_q;
  logic                deg_q;
  logic                issued_q;

  logic                m_valid_q;
  logic signed [W-1:0] out_est_q;
  logic [W-2:0]        out_cov_q;
  logic signed [W-1:0] out_gain_q;
  logic                out_deg_q;

  logic                in_xfer;
  logic                is_mul_step;
  logic                den_pos;
  logic                out_load;

  logic                mul_start, mul_done, mul_cov;
  logic signed [W-1:0] mul_a, mul_b, mul_add, mul_res;
  logic                div_start, div_done;
  logic signed [W-1:0] div_quot;

  logic signed [W-1:0] minuend;
  logic signed [W:0]   sub_d;
  logic signed [W-1:0] sub_sat;

  assign in_xfer  = s_axis_tvalid && s_axis_tready;
  assign den_pos  = !den_q[W-1] && (den_q != '0);
  assign out_load = (state_q == ST_OUT) && (!m_valid_q || m_axis_tready);

  always_comb begin
    case (state_q)
      ST_XP, ST_FP, ST_PP, ST_PH, ST_DEN, ST_HX, ST_XU, ST_KH, ST_PU: is_mul_step = 1'b1;
      default: is_mul_step = 1'b0;
    endcase
  end

  // shared saturating subtract for the residual and for 1 - K*H
  assign minuend = (state_q == ST_OM) ? ONE_Q : z_q;
  assign sub_d   = {minuend[W-1], minuend} - {t_q[W-1], t_q};
  assign sub_sat = (sub_d[W] != sub_d[W-1]) ? (sub_d[W] ? SMIN_W : SMAX_W) : sub_d[W-1:0];

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE: if (s_axis_tvalid) state_d = ST_XP;
      ST_XP:   if (mul_done) state_d = ST_FP;
      ST_FP:   if (mul_done) state_d = ST_PP;
      ST_PP:   if (mul_done) state_d = ST_PH;
      ST_PH:   if (mul_done) state_d = ST_DEN;
      ST_DEN:  if (mul_done) state_d = ST_DIV;
      ST_DIV:  if (!den_pos || div_done) state_d = ST_HX;
      ST_HX:   if (mul_done) state_d = ST_ERR;
      ST_ERR:  state_d = ST_XU;
      ST_XU:   if (mul_done) state_d = ST_KH;
      ST_KH:   if (mul_done) state_d = ST_OM;
      ST_OM:   state_d = ST_PU;
      ST_PU:   if (mul_done) state_d = ST_OUT;
      ST_OUT:  if (out_load) state_d = ST_IDLE;
      default: state_d = ST_IDLE;
    endcase
  end

  always_comb begin
    s_axis_tready = (state_q == ST_IDLE);
    mul_start     = is_mul_step && !issued_q;
    div_start     = (state_q == ST_DIV) && !issued_q && den_pos;
    mul_a         = f_q;
    mul_b         = x_q;
    mul_add       = '0;
    mul_cov       = 1'b0;
    unique case (state_q)
      ST_XP: begin
        mul_a = f_q;
        mul_b = x_q;
      end
      ST_FP: begin
        mul_a = f_q;
        mul_b = p_q;
      end
      ST_PP: begin
        mul_a   = t_q;
        mul_b   = f_q;
        mul_add = {1'b0, q_q};
        mul_cov = 1'b1;
      end
      ST_PH: begin
        mul_a = pp_q;
        mul_b = h_q;
      end
      ST_DEN: begin
        mul_a   = h_q;
        mul_b   = ph_q;
        mul_add = {1'b0, r_q};
      end
      ST_HX: begin
        mul_a = h_q;
        mul_b = xp_q;
      end
      ST_XU: begin
        mul_a   = k_q;
        mul_b   = e_q;
        mul_add = xp_q;
      end
      ST_KH: begin
        mul_a = k_q;
        mul_b = h_q;
      end
      ST_PU: begin
        mul_a   = om_q;
        mul_b   = pp_q;
        mul_cov = 1'b1;
      end
      default: begin
        mul_a = f_q;
      end
    endcase
  end

  skf_mul #(
    .DATA_WIDTH (DATA_WIDTH),
    .FRAC_BITS  (FRAC_BITS)
  ) u_mul (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .start_i   (mul_start),
    .op_a_i    (mul_a),
    .op_b_i    (mul_b),
    .addend_i  (mul_add),
    .cov_sat_i (mul_cov),
    .done_o    (mul_done),
    .result_o  (mul_res)
  );

  skf_div #(
    .DATA_WIDTH (DATA_WIDTH),
    .FRAC_BITS  (FRAC_BITS)
  ) u_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (div_start),
    .num_i   (ph_q),
    .den_i   (den_q),
    .done_o  (div_done),
    .quot_o  (div_quot)
  );

  // control, filter state and configuration
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= ST_IDLE;
      issued_q  <= 1'b0;
      m_valid_q <= 1'b0;
      f_q       <= ONE_Q;
      h_q       <= ONE_Q;
      q_q       <= TENTH_Q;
      r_q       <= TENTH_Q;
      x_q       <= '0;
      p_q       <= ONE_Q;
    end else begin
      state_q <= state_d;
      if (mul_done || div_done) begin
        issued_q <= 1'b0;
      end else if (mul_start || div_start) begin
        issued_q <= 1'b1;
      end
      if (out_load) begin
        m_valid_q <= 1'b1;
      end else if (m_axis_tready) begin
        m_valid_q <= 1'b0;
      end
      if (cfg_we_i) begin
        unique case (cfg_index_i)
          CFG_TRANSITION:  f_q <= cfg_wdata_i;
          CFG_OBSERVATION: h_q <= cfg_wdata_i;
          CFG_PROC_NOISE:  q_q <= cfg_wdata_i[W-2:0];
          CFG_MEAS_NOISE:  r_q <= cfg_wdata_i[W-2:0];
          default: ;
        endcase
      end
      if (mul_done && state_q == ST_XU) begin
        x_q <= mul_res;
      end
      if (mul_done && state_q == ST_PU) begin
        p_q <= mul_res;
      end
    end
  end

  // intermediate values of one step
  always_ff @(posedge clk_i) begin
    if (in_xfer) begin
      z_q   <= s_axis_tdata[W-1:0];
      deg_q <= 1'b0;
    end
    if (mul_done) begin
      case (state_q)
        ST_XP:             xp_q  <= mul_res;
        ST_PP:             pp_q  <= mul_res;
        ST_PH:             ph_q  <= mul_res;
        ST_DEN:            den_q <= mul_res;
        ST_FP, ST_HX, ST_KH: t_q <= mul_res;
        default: ;
      endcase
    end
    if (state_q == ST_DIV) begin
      if (!den_pos) begin
        k_q   <= '0;
        deg_q <= 1'b1;
      end else if (div_done) begin
        k_q <= div_quot;
      end
    end
    if (state_q == ST_ERR) begin
      e_q <= sub_sat;
    end
    if (state_q == ST_OM) begin
      om_q <= sub_sat;
    end
    if (out_load) begin
      out_est_q  <= x_q;
      out_cov_q  <= p_q[W-2:0];
      out_gain_q <= k_q;
      out_deg_q  <= deg_q;
    end
  end

  assign m_axis_tvalid = m_valid_q;
  assign m_axis_tdata  = OutDataW'({out_gain_q, out_cov_q, out_est_q});
  assign m_axis_tuser  = out_deg_q;

endmodule
